[design/mme_pkg.sv]
// Shared types and constants for the matrix multiply engine.
package mme_pkg;

  localparam int DIM_BITS     = 4;   // width of each dimension register
  localparam int IDX_BITS     = 3;   // row / column index width on the result
  localparam int IN_BITS      = 16;  // element width on the input channel
  localparam int PRODUCT_BITS = 40;  // result width, Q24.16
  localparam int WIDE_BITS    = 64;  // widest single product (32 x 32)

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS_A     = 2'd0;
  localparam logic [1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [1:0] REG_COLS_B     = 2'd2;

  typedef struct packed {
    logic signed [IN_BITS-1:0] element;
    logic                      matrix_end;
  } in_item_t;

  typedef struct packed {
    logic signed [PRODUCT_BITS-1:0] product;
    logic [IDX_BITS-1:0]            row_index;
    logic [IDX_BITS-1:0]            col_index;
    logic                           run_end;
    logic                           status;
  } out_item_t;

  // One issued term of a dot product
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

[design/matrix_multiply_engine_top.sv]
// Top level of the matrix multiply engine: load sequencer, product sequencer.
//
//  Port group  Dir   Handshake            Carries
//  in_         in    in_valid/in_ready    element (Q8.8), matrix_end
//  out_        out   out_valid/out_ready  product (Q24.16), row, col, run_end, status
//  cfg_        in    cfg_we               rows_a, inner_size, cols_b by index
//
// Loading takes an item whenever in_ready is high; A and B go into two
// stores, each with one write port and one registered read port.
// The item that closes B starts the product: each entry runs inner_size
// terms through the one shared multiply-accumulate (read, multiply,
// accumulate, hand-off), rows_a * cols_b entries in all.
// in_ready stays low while the product runs.
// Reset is synchronous; it clears the sequencer and the load state, while the
// stores keep whatever they held. A stalled result holds in the output
// register, and the product sequencer waits on it before the next entry.
module matrix_multiply_engine_top #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mme_pkg::in_item_t             in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output mme_pkg::out_item_t            out_data,
  // configuration port
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [mme_pkg::DIM_BITS-1:0]  cfg_wdata
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DB    = mme_pkg::DIM_BITS;
  localparam int IB    = mme_pkg::IDX_BITS;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ISSUE,
    S_DRAIN,
    S_EMIT
  } state_t;

  // Clamp a dimension register: zero acts as one, large values as MAX_DIM
  function automatic logic [DB-1:0] eff_dim(input logic [DB-1:0] v);
    logic [DB-1:0] res;
    res = v;
    if (v == '0) begin
      res = DB'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = DB'(MAX_DIM);
    end
    return res;
  endfunction

  state_t                 state_r;
  logic [DB-1:0]          rows_a_r;
  logic [DB-1:0]          inner_size_r;
  logic [DB-1:0]          cols_b_r;
  logic [CW-1:0]          load_cnt_r;
  logic                   loading_second_r;
  logic [IB-1:0]          i_r;
  logic [IB-1:0]          j_r;
  logic [IB-1:0]          k_r;
  logic [AW-1:0]          row_base_r;
  logic [AW-1:0]          a_ptr_r;
  logic [AW-1:0]          b_ptr_r;
  logic                   out_valid_r;
  mme_pkg::out_item_t     out_r;

  logic [DB-1:0]          ra;
  logic [DB-1:0]          kn;
  logic [DB-1:0]          cb;
  logic [2*DB-1:0]        expected;
  logic [CW-1:0]          load_cnt_nxt;
  logic                   in_fire;
  logic                   count_err;
  logic                   slot_free;
  logic                   out_load;
  logic                   last_k;
  logic                   last_col;
  logic                   last_entry;
  logic [ELEM_BITS-1:0]   elem_store;
  mme_pkg::mac_ctl_t      mac_ctl;
  logic [ELEM_BITS-1:0]   a_rd;
  logic [ELEM_BITS-1:0]   b_rd;
  logic [mme_pkg::PRODUCT_BITS-1:0] acc;
  logic                   mac_done;

  assign ra = eff_dim(rows_a_r);
  assign kn = eff_dim(inner_size_r);
  assign cb = eff_dim(cols_b_r);

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_LOAD) && slot_free;
  assign in_fire   = in_valid && in_ready;

  // Element count check on each loaded item
  assign expected     = loading_second_r ? kn * cb : ra * kn;
  assign load_cnt_nxt = load_cnt_r + CW'(1);
  assign count_err    = in_data.matrix_end ? (8'(load_cnt_nxt) != expected)
                                           : (8'(load_cnt_nxt) >= expected);

  // A new result enters the output register: an error item or a finished entry
  assign out_load = (in_fire && count_err) || ((state_r == S_EMIT) && slot_free);

  // Keep the low ELEM_BITS of the sign-extended element
  assign elem_store = ELEM_BITS'(in_data.element);

  assign last_k     = (DB'(k_r) == kn - DB'(1));
  assign last_col   = (DB'(j_r) == cb - DB'(1));
  assign last_entry = last_col && (DB'(i_r) == ra - DB'(1));

  // One term issued per cycle while walking the inner dimension
  always_comb begin
    mac_ctl       = '0;
    mac_ctl.valid = (state_r == S_ISSUE);
    mac_ctl.first = (k_r == '0);
    mac_ctl.last  = last_k;
  end

  mme_store #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH), .AW(AW)) u_store_a (
    .clk   (clk),
    .we    (in_fire && !loading_second_r),
    .waddr (load_cnt_r[AW-1:0]),
    .wdata (elem_store),
    .raddr (a_ptr_r),
    .rdata (a_rd)
  );

  mme_store #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH), .AW(AW)) u_store_b (
    .clk   (clk),
    .we    (in_fire && loading_second_r),
    .waddr (load_cnt_r[AW-1:0]),
    .wdata (elem_store),
    .raddr (b_ptr_r),
    .rdata (b_rd)
  );

  mme_mac #(.ELEM_BITS(ELEM_BITS)) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (mac_ctl),
    .a_i    (a_rd),
    .b_i    (b_rd),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_LOAD;
      rows_a_r         <= DB'(1);
      inner_size_r     <= DB'(1);
      cols_b_r         <= DB'(1);
      load_cnt_r       <= '0;
      loading_second_r <= 1'b0;
      i_r              <= '0;
      j_r              <= '0;
      k_r              <= '0;
      row_base_r       <= '0;
      a_ptr_r          <= '0;
      b_ptr_r          <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      // Configuration writes; an index beyond the list is dropped
      if (cfg_we) begin
        case (cfg_index)
          mme_pkg::REG_ROWS_A:     rows_a_r     <= cfg_wdata;
          mme_pkg::REG_INNER_SIZE: inner_size_r <= cfg_wdata;
          mme_pkg::REG_COLS_B:     cols_b_r     <= cfg_wdata;
          default: ;
        endcase
      end

      // Load a new result, else retire the waiting one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_LOAD: begin
          if (in_fire) begin
            if (count_err) begin
              // Bad count: one error result, restart at matrix A
              load_cnt_r        <= '0;
              loading_second_r  <= 1'b0;
              out_r.product     <= '0;
              out_r.row_index   <= '0;
              out_r.col_index   <= '0;
              out_r.run_end     <= 1'b1;
              out_r.status      <= 1'b1;
            end else if (!in_data.matrix_end) begin
              load_cnt_r <= load_cnt_nxt;
            end else if (!loading_second_r) begin
              load_cnt_r       <= '0;
              loading_second_r <= 1'b1;
            end else begin
              // B complete: start the product at entry (0, 0)
              load_cnt_r <= '0;
              i_r        <= '0;
              j_r        <= '0;
              k_r        <= '0;
              row_base_r <= '0;
              a_ptr_r    <= '0;
              b_ptr_r    <= '0;
              state_r    <= S_ISSUE;
            end
          end
        end

        S_ISSUE: begin
          // Walk row of A by one, column of B by cols_b
          k_r     <= k_r + IB'(1);
          a_ptr_r <= a_ptr_r + AW'(1);
          b_ptr_r <= b_ptr_r + AW'(cb);
          if (last_k) begin
            state_r <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          if (mac_done) begin
            state_r <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (slot_free) begin
            out_r.product   <= acc;
            out_r.row_index <= i_r;
            out_r.col_index <= j_r;
            out_r.run_end   <= last_entry;
            out_r.status    <= 1'b0;
            k_r             <= '0;
            if (last_entry) begin
              loading_second_r <= 1'b0;
              state_r          <= S_LOAD;
            end else if (last_col) begin
              i_r        <= i_r + IB'(1);
              j_r        <= '0;
              row_base_r <= row_base_r + AW'(kn);
              a_ptr_r    <= row_base_r + AW'(kn);
              b_ptr_r    <= '0;
              state_r    <= S_ISSUE;
            end else begin
              j_r     <= j_r + IB'(1);
              a_ptr_r <= row_base_r;
              b_ptr_r <= AW'(j_r) + AW'(1);
              state_r <= S_ISSUE;
            end
          end
        end

        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The accumulator finishes an entry only while the sequencer waits for it
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == S_DRAIN))
    else $error("accumulator finished outside drain");

  // An error result carries a zero product and closes the run
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status) |-> (out_r.run_end && (out_r.product == '0)))
    else $error("malformed error result");

  // The load count never reaches the store depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (int'(load_cnt_r) < DEPTH))
    else $error("load count out of range");

  // After the last entry goes out, loading restarts at matrix A
  a_restart_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && slot_free && last_entry)
      |=> (state_r == S_LOAD && !loading_second_r && load_cnt_r == '0))
    else $error("no restart after final entry");

  // No item is taken while a product is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE || state_r == S_DRAIN) |=> !$rose(in_ready) || (state_r == S_LOAD))
    else $error("input accepted during product");

endmodule

[design/mme_store.sv]
// Element store: one write port, one read port with registered read data.
module mme_store #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/mme_mac.sv]
// Shared multiply-accumulate unit: aligns control with store reads,
// registers the product, then accumulates modulo 2^40.
module mme_mac #(
  parameter int ELEM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mme_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [ELEM_BITS-1:0]         a_i,
  input  logic signed [ELEM_BITS-1:0]         b_i,
  output logic [mme_pkg::PRODUCT_BITS-1:0]    acc_o,
  output logic                                done_o
);

  mme_pkg::mac_ctl_t                    ctl1_r;
  mme_pkg::mac_ctl_t                    ctl2_r;
  logic signed [2*ELEM_BITS-1:0]        prod_r;
  logic [mme_pkg::PRODUCT_BITS-1:0]     acc_r;
  logic                                 done_r;
  logic signed [mme_pkg::WIDE_BITS-1:0] prod_ext;
  logic [mme_pkg::PRODUCT_BITS-1:0]     term;

  assign prod_ext = mme_pkg::WIDE_BITS'(prod_r);
  assign term     = prod_ext[mme_pkg::PRODUCT_BITS-1:0];

  // Control: stage 1 lines up with read data, stage 2 with the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.valid && ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
    if (ctl2_r.valid) begin
      acc_r <= ctl2_r.first ? term : acc_r + term;
    end
  end

  assign acc_o  = acc_r;
  assign done_o = done_r;

endmodule

[tb/matrix_multiply_engine_top_tb.sv]
// Self-checking testbench for matrix_multiply_engine_top: streamed A*B products.
`timescale 1ns / 1ps

module matrix_multiply_engine_top_tb;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_CYCLES  = 800;  // long receiver stall, fills the block
  localparam int SETTLE_CYCLES = 20;  // load path takes one item per cycle while in_ready is high

  // How a matrix load is closed
  typedef enum logic [1:0] {
    SEQ_GOOD,     // end mark on the last element
    SEQ_EARLY,    // end mark before the expected count
    SEQ_MISSING   // expected count reached without an end mark
  } load_kind_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  mme_pkg::in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  mme_pkg::out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = mme_pkg::REG_ROWS_A;
  logic [mme_pkg::DIM_BITS-1:0] cfg_wdata = '0;

  matrix_multiply_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: dimension registers, both operand stores, load state.
  // Registers change only while the block is idle, so the driver can read them
  // at acceptance time without any ordering concern.
  // ---------------------------------------------------------------------------
  logic [mme_pkg::DIM_BITS-1:0]      rows_reg  = 4'd1;
  logic [mme_pkg::DIM_BITS-1:0]      inner_reg = 4'd1;
  logic [mme_pkg::DIM_BITS-1:0]      cols_reg  = 4'd1;
  logic signed [mme_pkg::IN_BITS-1:0] a_store [STORE_DEPTH];
  logic signed [mme_pkg::IN_BITS-1:0] b_store [STORE_DEPTH];
  logic [6:0]               load_count = '0;
  logic                     loading_b  = 1'b0;

  mme_pkg::in_item_t    element_queue[$];    // items waiting for the driver
  mme_pkg::out_item_t   awaited_results[$];  // predicted product entries, oldest first
  int unsigned queued_items   = 0;
  int unsigned accepted_items = 0;
  int unsigned mismatches     = 0;

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 81;
  logic        hold_arm  = 1'b0;
  logic        hold_used = 1'b0;
  int unsigned hold_left = 0;

  // Register value 0 behaves as 1, anything above MAX_DIM as MAX_DIM
  function automatic int unsigned dim_of(input logic [mme_pkg::DIM_BITS-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return r;
  endfunction

  // Advance the shadow by one accepted item and queue the entries it produces
  task automatic load_element(input mme_pkg::in_item_t item);
    int unsigned ra, kn, cb, full;
    logic signed [mme_pkg::PRODUCT_BITS-1:0] acc, a_term, b_term;
    mme_pkg::out_item_t res;
    ra = dim_of(rows_reg);
    kn = dim_of(inner_reg);
    cb = dim_of(cols_reg);
    full = loading_b ? kn * cb : ra * kn;
    if (load_count < STORE_DEPTH) begin
      if (loading_b) b_store[load_count[5:0]] = item.element;
      else a_store[load_count[5:0]] = item.element;
    end
    load_count = load_count + 7'd1;

    // Early or missing end mark: one error entry, restart at matrix A
    if ((item.matrix_end && load_count != full) ||
        (!item.matrix_end && load_count >= full)) begin
      load_count = '0;
      loading_b  = 1'b0;
      res = '0;
      res.run_end = 1'b1;
      res.status  = 1'b1;
      awaited_results = {awaited_results, res};
      return;
    end
    if (!item.matrix_end) return;

    // End of A: nothing out, switch to B
    if (!loading_b) begin
      load_count = '0;
      loading_b  = 1'b1;
      return;
    end

    // End of B: whole product, row-major, exact dot products
    for (int unsigned i = 0; i < ra; i++) begin
      for (int unsigned j = 0; j < cb; j++) begin
        acc = '0;
        for (int unsigned k = 0; k < kn; k++) begin
          a_term = a_store[(i * kn + k) % STORE_DEPTH];
          b_term = b_store[(k * cb + j) % STORE_DEPTH];
          acc += a_term * b_term;
        end
        res = '0;
        res.product   = acc;
        res.row_index = mme_pkg::IDX_BITS'(i);
        res.col_index = mme_pkg::IDX_BITS'(j);
        res.run_end   = (i == ra - 1) && (j == cb - 1);
        awaited_results = {awaited_results, res};
      end
    end
    load_count = '0;
    loading_b  = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: predict on acceptance, then refill the slot from the queue or idle.
  // Valid only drops once the held item has gone through.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        load_element(in_data);
        accepted_items = accepted_items + 1;
      end
      if (!in_valid || in_ready) begin
        if (element_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= element_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus, counted down here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every accepted result with the oldest prediction, field by
  // field; X on the output counts as a mismatch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    mme_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data), 64'd0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.product !== want.product)
            report_mismatch("product", 64'(out_data.product), 64'(want.product));
          if (out_data.row_index !== want.row_index)
            report_mismatch("row_index", 64'(out_data.row_index), 64'(want.row_index));
          if (out_data.col_index !== want.col_index)
            report_mismatch("col_index", 64'(out_data.col_index), 64'(want.col_index));
          if (out_data.run_end !== want.run_end)
            report_mismatch("run_end", 64'(out_data.run_end), 64'(want.run_end));
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [mme_pkg::IN_BITS-1:0] random_element();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return mme_pkg::IN_BITS'($urandom);
    endcase
  endfunction

  // Mostly small sizes; 0 and values past MAX_DIM now and then
  function automatic logic [mme_pkg::DIM_BITS-1:0] random_dim();
    case ($urandom_range(0, 9))
      7:       return 4'd0;
      8:       return mme_pkg::DIM_BITS'($urandom_range(4, 7));
      9:       return mme_pkg::DIM_BITS'($urandom_range(8, 15));
      default: return mme_pkg::DIM_BITS'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic load_kind_t pick_fault();
    return $urandom_range(0, 1) ? SEQ_EARLY : SEQ_MISSING;
  endfunction

  task automatic push_item(input logic [mme_pkg::IN_BITS-1:0] value, input logic mark);
    mme_pkg::in_item_t item;
    item.element    = value;
    item.matrix_end = mark;
    element_queue = {element_queue, item};
    queued_items++;
  endtask

  // Push one matrix of n elements; an early end needs at least two elements,
  // so a one-element matrix falls back to a missing end mark
  task automatic push_matrix(input int unsigned n, input load_kind_t kind);
    int unsigned count;
    logic        mark_last;
    count     = n;
    mark_last = (kind == SEQ_GOOD) || (kind == SEQ_EARLY && n >= 2);
    if (kind == SEQ_EARLY && n >= 2) count = $urandom_range(1, n - 1);
    for (int unsigned i = 1; i <= count; i++)
      push_item(random_element(), (i == count) && mark_last);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [mme_pkg::DIM_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_dims(input logic [mme_pkg::DIM_BITS-1:0] r,
                          input logic [mme_pkg::DIM_BITS-1:0] k,
                          input logic [mme_pkg::DIM_BITS-1:0] c);
    write_reg(mme_pkg::REG_ROWS_A, r);
    write_reg(mme_pkg::REG_INNER_SIZE, k);
    write_reg(mme_pkg::REG_COLS_B, c);
    rows_reg  = r;
    inner_reg = k;
    cols_reg  = c;
  endtask

  // Wait until every queued item is taken and every prediction has been met,
  // then give the load path a few cycles to finish items that produce nothing
  task automatic drain();
    while (accepted_items != queued_items || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drain, then make a register change safe: never stop halfway into B (the
  // product would read entries the new sizes never wrote). A partial A may be
  // left over on purpose so the next sizes can overrun it.
  task automatic settle();
    drain();
    while (loading_b || (load_count != 0 && $urandom_range(0, 3) != 0)) begin
      push_item(random_element(), 1'b1);
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned base;
    int unsigned ra, kn, cb;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 1x1x1 with the element extremes
    set_dims(4'd1, 4'd1, 4'd1);
    push_item(16'h7FFF, 1'b1);
    push_item(16'h7FFF, 1'b1);
    push_item(16'h8000, 1'b1);
    push_item(16'h8000, 1'b1);
    push_item(16'h8000, 1'b1);
    push_item(16'h7FFF, 1'b1);
    settle();

    // Directed: early and missing end marks, in A and in B
    set_dims(4'd1, 4'd2, 4'd1);
    push_matrix(2, SEQ_EARLY);
    push_matrix(2, SEQ_MISSING);
    push_matrix(2, SEQ_GOOD);
    push_matrix(2, SEQ_EARLY);
    push_matrix(2, SEQ_GOOD);
    push_matrix(2, SEQ_MISSING);
    settle();

    // Directed: out-of-range registers, 15 acts as 8 and 0 as 1
    set_dims(4'd15, 4'd0, 4'd0);
    push_matrix(8, SEQ_GOOD);
    push_matrix(1, SEQ_GOOD);
    settle();

    base = queued_items;

    // Full 8x8x8 product with the receiver held off: the sender keeps
    // offering the next load while the product stalls on the output register
    set_dims(4'd8, 4'd9, 4'd15);
    hold_arm <= 1'b1;
    push_matrix(64, SEQ_GOOD);
    push_matrix(64, SEQ_GOOD);
    repeat (10) push_item(random_element(), 1'b0);
    settle();

    // Random phases: new sizes each time, mostly clean A/B loads
    while (queued_items - base < RANDOM_ITEMS) begin
      case ((queued_items - base) * 3 / RANDOM_ITEMS)
        0: begin
          send_idle_pct <= 28;
          recv_idle_pct <= 81;
        end
        1: begin
          send_idle_pct <= 81;
          recv_idle_pct <= 28;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      set_dims(random_dim(), random_dim(), random_dim());
      ra = dim_of(rows_reg);
      kn = dim_of(inner_reg);
      cb = dim_of(cols_reg);
      repeat ($urandom_range(2, 5)) begin
        case ($urandom_range(0, 9))
          0: push_matrix(ra * kn, pick_fault());
          1: begin
            push_matrix(ra * kn, SEQ_GOOD);
            push_matrix(kn * cb, pick_fault());
          end
          2: begin
            // stray elements with an occasional end mark
            repeat ($urandom_range(1, 3))
              push_item(random_element(), $urandom_range(0, 3) == 0);
          end
          default: begin
            push_matrix(ra * kn, SEQ_GOOD);
            push_matrix(kn * cb, SEQ_GOOD);
          end
        endcase
      end
      settle();
    end

    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
